[rtl/quoted_word_scanner_defines.svh]
// Assertion macros used by the quoted_word_scanner RTL.
`ifndef QUOTED_WORD_SCANNER_DEFINES_SVH
`define QUOTED_WORD_SCANNER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define QWS_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define QWS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/qws_pkg.sv]
package qws_pkg;

    // Scan phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_NAME   = 2'd3;

    // Quote mode codes
    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_DOUBLE = 2'd1;
    localparam logic [1:0] QM_SINGLE = 2'd2;

    // Special characters
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [7:0] DELIM_RESET = 8'h20;

    // Output length fields
    localparam int          OUT_W   = 12;
    localparam logic [11:0] OUT_MAX = 12'hFFF;

    typedef struct packed {
        logic [1:0] quote_mode;
        logic [1:0] phase;
        logic [7:0] lead_char;
    } scan_state_t;

    typedef struct packed {
        logic       fire;        // step produces a result (kept character or word end)
        logic [7:0] char_out;
        logic       char_valid;
        logic       word_done;
    } step_result_t;

endpackage

[rtl/qws_step.sv]
module qws_step
    import qws_pkg::*;
#(
    parameter int LEN_BITS = 12
) (
    input  logic [7:0]          byte_in,
    input  logic                start_word,
    input  logic [7:0]          delimiter,
    input  scan_state_t         state_cur,
    input  logic [LEN_BITS-1:0] kept_cur,
    input  logic [LEN_BITS-1:0] cons_cur,
    output scan_state_t         state_next,
    output logic [LEN_BITS-1:0] kept_next,
    output logic [LEN_BITS-1:0] cons_next,
    output step_result_t        result
);

    localparam logic [1:0] ACT_IGNORE = 2'd0;
    localparam logic [1:0] ACT_EMIT   = 2'd1;
    localparam logic [1:0] ACT_DROP   = 2'd2;
    localparam logic [1:0] ACT_END    = 2'd3;

    logic [1:0]          act;
    logic [1:0]          eff_phase;
    logic                is_redir;
    logic                is_skip_delim;
    logic                use_name;
    logic [LEN_BITS-1:0] kept_base;
    logic [LEN_BITS-1:0] cons_base;
    scan_state_t         base;

    assign is_redir      = byte_in inside {CH_LT, CH_GT};
    assign is_skip_delim = (byte_in != CH_NUL) && (byte_in == delimiter);

    always_comb
    begin
        // A new word clears everything before the byte is looked at.
        base       = state_cur;
        kept_base  = kept_cur;
        cons_base  = cons_cur;
        eff_phase  = state_cur.phase;
        if (start_word)
        begin
            base.quote_mode = QM_NONE;
            base.lead_char  = CH_NUL;
            kept_base       = '0;
            cons_base       = '0;
            eff_phase       = PH_NAME;
        end

        state_next = base;
        act        = ACT_IGNORE;
        use_name   = 1'b0;

        if (start_word && is_redir)
        begin
            state_next.lead_char = byte_in;
            state_next.phase     = PH_SECOND;
            act                  = ACT_EMIT;
        end
        else
        begin
            case (eff_phase)
                PH_SECOND:
                begin
                    state_next.phase = PH_SKIP;
                    if (byte_in == base.lead_char)
                        act = ACT_EMIT;
                    else if (is_redir || is_skip_delim)
                        act = ACT_DROP;
                    else
                        use_name = 1'b1;
                end
                PH_SKIP:
                begin
                    if (is_skip_delim)
                        act = ACT_DROP;
                    else
                        use_name = 1'b1;
                end
                PH_NAME:
                begin
                    use_name = 1'b1;
                end
                default:
                begin
                    state_next.phase = PH_IDLE;
                end
            endcase
        end

        if (use_name)
        begin
            state_next.phase = PH_NAME;
            if (base.quote_mode == QM_NONE)
            begin
                if (byte_in == CH_NUL || byte_in == delimiter || is_redir)
                begin
                    state_next.phase = PH_IDLE;
                    act              = ACT_END;
                end
                else if (byte_in == CH_SQ || byte_in == CH_DQ)
                begin
                    state_next.quote_mode = (byte_in == CH_SQ) ? QM_SINGLE : QM_DOUBLE;
                    act                   = ACT_DROP;
                end
                else
                    act = ACT_EMIT;
            end
            else
            begin
                if (byte_in == CH_NUL)
                begin
                    state_next.phase      = PH_IDLE;
                    state_next.quote_mode = QM_NONE;
                    act                   = ACT_END;
                end
                else if ((base.quote_mode == QM_DOUBLE && byte_in == CH_DQ) ||
                         (base.quote_mode != QM_DOUBLE && byte_in == CH_SQ))
                begin
                    state_next.quote_mode = QM_NONE;
                    act                   = ACT_DROP;
                end
                else
                    act = ACT_EMIT;
            end
        end

        // Saturating counts
        kept_next = kept_base;
        cons_next = cons_base;
        if (act == ACT_EMIT || act == ACT_DROP)
        begin
            if (cons_base != '1)
                cons_next = cons_base + LEN_BITS'(1);
        end
        if (act == ACT_EMIT)
        begin
            if (kept_base != '1)
                kept_next = kept_base + LEN_BITS'(1);
        end

        result.fire       = (act == ACT_EMIT) || (act == ACT_END);
        result.char_valid = (act == ACT_EMIT);
        result.char_out   = (act == ACT_EMIT) ? byte_in : CH_NUL;
        result.word_done  = (act == ACT_END);
    end

endmodule

[rtl/quoted_word_scanner.sv]
// Channel  | handshake              | word
// ---------+------------------------+-------------------------------------------
// input    | in_valid / in_ready    | byte_in, start_word
// output   | out_valid / out_ready  | char_out, char_valid, word_done,
//          |                        | word_len, raw_len
// config   | cfg_we                 | cfg_data (delimiter byte)
//
// One byte is taken per cycle while in_ready is high; a kept character or the
// word end shows in the cycle after its byte is taken. One result register
// sets the rate. in_ready drops only while a result waits and out_ready is low.
// Bytes that are dropped (quote marks, skipped delimiters) give no result.
// rst_n clears the scan to idle, both counts to zero and the delimiter to
// a space.
module quoted_word_scanner
    import qws_pkg::*;
#(
    parameter int LEN_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        start_word,
    // delimiter register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_out,
    output logic        char_valid,
    output logic        word_done,
    output logic [11:0] word_len,
    output logic [11:0] raw_len
);

`include "quoted_word_scanner_defines.svh"

    localparam int EXT_W = (LEN_BITS > OUT_W) ? LEN_BITS : OUT_W;

    logic [7:0]          delim_reg;
    scan_state_t         state_reg;
    scan_state_t         state_next;
    logic [LEN_BITS-1:0] kept_reg;
    logic [LEN_BITS-1:0] kept_next;
    logic [LEN_BITS-1:0] cons_reg;
    logic [LEN_BITS-1:0] cons_next;
    step_result_t        res;
    logic                in_fire;
    logic [EXT_W-1:0]    kept_ext;
    logic [EXT_W-1:0]    cons_ext;
    logic [11:0]         word_len_next;
    logic [11:0]         raw_len_next;

    logic                out_valid_reg;
    logic [7:0]          char_reg;
    logic                char_valid_reg;
    logic                word_done_reg;
    logic [11:0]         word_len_reg;
    logic [11:0]         raw_len_reg;

    // Accept whenever the result register is free or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    qws_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .byte_in    (byte_in),
        .start_word (start_word),
        .delimiter  (delim_reg),
        .state_cur  (state_reg),
        .kept_cur   (kept_reg),
        .cons_cur   (cons_reg),
        .state_next (state_next),
        .kept_next  (kept_next),
        .cons_next  (cons_next),
        .result     (res)
    );

    // On the ending byte the counts do not move, so the next values are the
    // lengths to report. Clamp them to the 12-bit output field.
    assign kept_ext      = EXT_W'(kept_next);
    assign cons_ext      = EXT_W'(cons_next);
    assign word_len_next = !res.word_done ? 12'd0 :
                           (kept_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : kept_ext[OUT_W-1:0];
    assign raw_len_next  = !res.word_done ? 12'd0 :
                           (cons_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : cons_ext[OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg            <= DELIM_RESET;
            state_reg.quote_mode <= QM_NONE;
            state_reg.phase      <= PH_IDLE;
            state_reg.lead_char  <= CH_NUL;
            kept_reg             <= '0;
            cons_reg             <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                delim_reg <= cfg_data;
            // Advance the scan on every accepted byte.
            if (in_fire)
            begin
                state_reg <= state_next;
                kept_reg  <= kept_next;
                cons_reg  <= cons_next;
            end
            if (in_fire && res.fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load with each result, hold while stalled.
    always_ff @(posedge clk)
    begin
        if (in_fire && res.fire)
        begin
            char_reg       <= res.char_out;
            char_valid_reg <= res.char_valid;
            word_done_reg  <= res.word_done;
            word_len_reg   <= word_len_next;
            raw_len_reg    <= raw_len_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_out   = char_reg;
    assign char_valid = char_valid_reg;
    assign word_done  = word_done_reg;
    assign word_len   = word_len_reg;
    assign raw_len    = raw_len_reg;

    `QWS_ASSERT_NOW(a_done_has_no_char,
        !(out_valid_reg && word_done_reg) || (!char_valid_reg && char_reg == CH_NUL),
        "word end carries a character")
    `QWS_ASSERT_NOW(a_len_only_on_done,
        !(out_valid_reg && !word_done_reg) || (word_len_reg == 12'd0 && raw_len_reg == 12'd0),
        "lengths shown without word end")
    `QWS_ASSERT_NEXT(a_idle_after_done, in_fire && res.word_done,
        state_reg.phase == PH_IDLE && state_reg.quote_mode == QM_NONE,
        "scan not idle after word end")
    `QWS_ASSERT_NOW(a_kept_within_raw, kept_reg <= cons_reg,
        "kept count above consumed count")

endmodule
